FILE: sv/dqsr_pkg.sv
// Shared constants, codes and types of the duplicate-free search-and-remove queue.
`timescale 1ns / 1ps

package dqsr_pkg;

	// Field widths fixed by the item formats.
	localparam int unsigned DATA_W = 32;
	localparam int unsigned OP_W   = 2;
	localparam int unsigned STAT_W = 3;
	localparam int unsigned POS_W  = 5;

	// Default number of live entries the queue can hold.
	localparam int unsigned QUEUE_DEPTH_DEF = 16;

	// Operation codes.
	localparam logic [OP_W-1:0] OP_ENQ    = 2'd0;
	localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
	localparam logic [OP_W-1:0] OP_LOCATE = 2'd2;
	localparam logic [OP_W-1:0] OP_COUNT  = 2'd3;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK       = 3'd0;
	localparam logic [STAT_W-1:0] ST_FULL     = 3'd1;
	localparam logic [STAT_W-1:0] ST_DUP      = 3'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd3;
	localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd4;

	// Control that every cell of the chain receives each cycle.
	typedef struct packed {
		logic shift;
		logic load;
	} dqsr_cell_ctl_t;

endpackage

FILE: sv/dqsr_req_if.sv
// Request channel: operation and operand, with valid/ready handshake.
`timescale 1ns / 1ps

interface dqsr_req_if;
	logic                                valid;
	logic                                ready;
	logic [dqsr_pkg::OP_W-1:0]           op;
	logic signed [dqsr_pkg::DATA_W-1:0]  value;

	modport source (output valid, output op, output value, input ready);
	modport sink   (input valid, input op, input value, output ready);
endinterface

FILE: sv/dqsr_rsp_if.sv
// Response channel: status, match position and occupancy, with valid/ready handshake.
`timescale 1ns / 1ps

interface dqsr_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [dqsr_pkg::STAT_W-1:0]   status;
	logic [dqsr_pkg::POS_W-1:0]    position;
	logic [dqsr_pkg::POS_W-1:0]    occupancy;

	modport source (output valid, output status, output position, output occupancy,
		input ready);
	modport sink   (input valid, input status, input position, input occupancy,
		output ready);
endinterface

FILE: sv/dedup_queue_search_remove_unit.sv
// Top level of the duplicate-free queue built as a chain of compare-and-shift cells.
//
//   channel | dir | handshake     | payload
//   req     | in  | valid / ready | op, value
//   rsp     | out | valid / ready | status, position, occupancy
//
// One item is worked at a time. Enqueue, locate, count and every refused operation
// are answered from the search state; a remove first shifts out the matching entry
// and all ahead of it, as the cell chain moves every entry one place per cycle.
// req.ready is high whenever no item is in work, also while a response waits.
// Reset clears the occupancy, the controller and the response valid; stored
// entries are not cleared and are never read until written.
`timescale 1ns / 1ps

module dedup_queue_search_remove_unit #(
	parameter int unsigned QUEUE_DEPTH = dqsr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dqsr_req_if.sink    req,
	dqsr_rsp_if.source  rsp
);
	import dqsr_pkg::*;

	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_SHIFT  = 2'd2;

	logic [1:0]               state_q, state_d;
	logic [CNT_W-1:0]         count_q, count_d;
	logic [CNT_W-1:0]         shift_left_q, shift_left_d;
	logic [CNT_W-1:0]         pos_q;
	logic [OP_W-1:0]          op_q;
	logic signed [DATA_W-1:0] value_q;
	logic                     rsp_valid_q;
	logic [STAT_W-1:0]        status_q;
	logic [POS_W-1:0]         position_q;
	logic [POS_W-1:0]         occupancy_q;

	logic signed [DATA_W-1:0] entry [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]   hit;
	logic                     any_hit;
	logic [IDX_W-1:0]         first_idx;
	logic                     can_emit;
	logic                     emit;
	logic [STAT_W-1:0]        emit_status;
	logic [CNT_W-1:0]         emit_pos;
	logic                     shift_en;
	logic                     load_en;
	logic                     accept;

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign can_emit  = !rsp_valid_q || rsp.ready;

	// Chain of cells; cell 0 is the head, each shift pulls from the next cell.
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		dqsr_cell_ctl_t                ctl;
		logic signed [DATA_W-1:0]      nxt;

		assign ctl.shift = shift_en;
		assign ctl.load  = load_en && (count_q == CNT_W'(i));

		if (i < QUEUE_DEPTH - 1) begin : g_mid
			assign nxt = entry[i+1];
		end else begin : g_last
			assign nxt = entry[i];
		end

		dqsr_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.live       (CNT_W'(i) < count_q),
			.value      (value_q),
			.next_entry (nxt),
			.entry      (entry[i]),
			.hit        (hit[i])
		);
	end

	// First matching cell from the head.
	always_comb begin
		first_idx = '0;
		any_hit   = 1'b0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (hit[i]) begin
				first_idx = IDX_W'(i);
				any_hit   = 1'b1;
			end
		end
	end

	// Controller: decide the outcome, drive the chain and form the response.
	always_comb begin
		state_d      = state_q;
		count_d      = count_q;
		shift_left_d = shift_left_q;
		emit         = 1'b0;
		emit_status  = ST_OK;
		emit_pos     = '0;
		shift_en     = 1'b0;
		load_en      = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					state_d = S_SEARCH;
				end
			end
			S_SEARCH: begin
				case (op_q)
					OP_ENQ: begin
						emit = can_emit;
						if (count_q == CNT_W'(QUEUE_DEPTH)) begin
							emit_status = ST_FULL;
						end else if (any_hit) begin
							emit_status = ST_DUP;
						end else begin
							load_en = can_emit;
							if (can_emit) begin
								count_d = count_q + CNT_W'(1);
							end
						end
					end
					OP_REMOVE: begin
						if (count_q == '0) begin
							emit        = can_emit;
							emit_status = ST_EMPTY;
						end else if (!any_hit) begin
							emit        = can_emit;
							emit_status = ST_NOTFOUND;
						end else begin
							state_d      = S_SHIFT;
							shift_left_d = CNT_W'(first_idx) + CNT_W'(1);
						end
					end
					OP_LOCATE: begin
						emit = can_emit;
						if (count_q == '0) begin
							emit_status = ST_EMPTY;
						end else if (!any_hit) begin
							emit_status = ST_NOTFOUND;
						end else begin
							emit_pos = CNT_W'(first_idx) + CNT_W'(1);
						end
					end
					default: begin
						emit = can_emit;
					end
				endcase
				if (emit) begin
					state_d = S_IDLE;
				end
			end
			S_SHIFT: begin
				if (shift_left_q != '0) begin
					shift_en     = 1'b1;
					count_d      = count_q - CNT_W'(1);
					shift_left_d = shift_left_q - CNT_W'(1);
				end else if (can_emit) begin
					emit     = 1'b1;
					emit_pos = pos_q;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Operand and response payload registers.
	always_ff @(posedge clk) begin
		shift_left_q <= shift_left_d;
		if (accept) begin
			op_q    <= req.op;
			value_q <= req.value;
		end
		if (state_q == S_SEARCH) begin
			pos_q <= shift_left_d;
		end
		if (emit) begin
			status_q    <= emit_status;
			position_q  <= POS_W'(emit_pos);
			occupancy_q <= POS_W'(count_d);
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.status    = status_q;
	assign rsp.position  = position_q;
	assign rsp.occupancy = occupancy_q;

endmodule

FILE: sv/dqsr_cell.sv
// One queue cell: holds an entry, compares it to the operand and shifts toward the head.
`timescale 1ns / 1ps

module dqsr_cell (
	input  logic                                clk,
	input  dqsr_pkg::dqsr_cell_ctl_t            ctl,
	input  logic                                live,
	input  logic signed [dqsr_pkg::DATA_W-1:0]  value,
	input  logic signed [dqsr_pkg::DATA_W-1:0]  next_entry,
	output logic signed [dqsr_pkg::DATA_W-1:0]  entry,
	output logic                                hit
);
	import dqsr_pkg::*;

	logic signed [DATA_W-1:0] entry_q;

	// A shift takes the neighbor's entry; a load takes the operand at the tail.
	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			entry_q <= next_entry;
		end else if (ctl.load) begin
			entry_q <= value;
		end
	end

	// Only a live entry can match.
	assign hit   = live && (entry_q == value);
	assign entry = entry_q;

endmodule

FILE: sv/dqsr_check.sv
// Port-level assertions for the queue top level, with the bind that attaches them.
`timescale 1ns / 1ps

module dqsr_check #(
	parameter int unsigned QUEUE_DEPTH = dqsr_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rsp_valid,
	input  logic                          rsp_ready,
	input  logic [dqsr_pkg::STAT_W-1:0]   rsp_status,
	input  logic [dqsr_pkg::POS_W-1:0]    rsp_position,
	input  logic [dqsr_pkg::POS_W-1:0]    rsp_occupancy
);
	import dqsr_pkg::*;

	localparam logic [POS_W-1:0] FULL_OCC = POS_W'(QUEUE_DEPTH);

	// A stalled response stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response dropped while stalled");

	// A refused operation reports no position.
	a_fail_no_pos: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != ST_OK) |-> rsp_position == '0)
		else $error("nonzero position on a failed operation");

	// An empty status means the queue holds nothing.
	a_empty_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_EMPTY) |-> rsp_occupancy == '0)
		else $error("empty status with entries held");

	// A full status means the queue holds its capacity.
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == ST_FULL) |-> rsp_occupancy == FULL_OCC)
		else $error("full status below capacity");

endmodule

bind dedup_queue_search_remove_unit dqsr_check #(
	.QUEUE_DEPTH (QUEUE_DEPTH)
) u_dqsr_check (
	.clk           (clk),
	.arst_n        (arst_n),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_status    (rsp.status),
	.rsp_position  (rsp.position),
	.rsp_occupancy (rsp.occupancy)
);

FILE: verif/tb.sv
// Self-checking testbench for the duplicate-free search-and-remove queue.
`timescale 1ns / 1ps

module tb;
	import dqsr_pkg::*;

	// Queue depth under test, and the shape of the run.
	localparam int unsigned DEPTH          = QUEUE_DEPTH_DEF;
	localparam int          RANDOM_CMDS    = 1470;
	localparam int          POOL_MAX       = 32;
	localparam int          BACKLOG_AFTER  = 400;
	localparam int          BACKLOG_CYCLES = 200;
	localparam int          DRAIN_CYCLES   = 2 * DEPTH + 8;
	// Worst quiet stretch: the longest send gap, the deepest remove and the longest
	// stall, or the single backlog; the limit is several times that.
	localparam int          WATCHDOG_LIMIT = 2000;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [DATA_W-1:0] value;
	} queue_cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [POS_W-1:0]  position;
		logic [POS_W-1:0]  occupancy;
	} queue_result_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	dqsr_req_if req ();
	dqsr_rsp_if rsp ();

	dedup_queue_search_remove_unit #(
		.QUEUE_DEPTH(DEPTH)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req),
		.rsp   (rsp)
	);

	// Free-running clock with a 2 ns period.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Commands still to send, results still to arrive, and the live queue contents.
	queue_cmd_t        pending_cmds[$];
	queue_result_t     awaited_results[$];
	logic [DATA_W-1:0] held_values[$];

	logic [DATA_W-1:0] value_pool[POOL_MAX];
	int                pool_used;

	bit            req_took;
	bit            rsp_took;
	int            items_accepted;
	int            results_checked;
	int            fail_count;
	int            idle_cycles;
	int            send_gap;
	int            hold_left;
	int            stall;
	bit            backlog_done;
	int            deepest_remove;
	int            op_count[4];
	int            status_count[8];
	queue_cmd_t    next_cmd;
	queue_cmd_t    taken_cmd;
	queue_result_t want;

	// Applies one command to the predicted queue and returns the result it yields.
	function automatic queue_result_t apply_queue_op(queue_cmd_t cmd);
		queue_result_t     res;
		int                hit;
		int                k;
		res.status   = ST_OK;
		res.position = '0;
		hit = -1;
		for (k = 0; k < held_values.size(); k++) begin
			if (hit < 0 && held_values[k] == cmd.value)
				hit = k;
		end
		case (cmd.op)
			OP_ENQ: begin
				if (held_values.size() >= DEPTH)
					res.status = ST_FULL;
				else if (hit >= 0)
					res.status = ST_DUP;
				else
					held_values.push_back(cmd.value);
			end
			OP_REMOVE, OP_LOCATE: begin
				if (held_values.size() == 0) begin
					res.status = ST_EMPTY;
				end else if (hit < 0) begin
					res.status = ST_NOTFOUND;
				end else begin
					res.position = POS_W'(hit + 1);
					if (cmd.op == OP_REMOVE) begin
						for (k = 0; k <= hit; k++)
							void'(held_values.pop_front());
					end
				end
			end
			default: begin
			end
		endcase
		res.occupancy = POS_W'(held_values.size());
		return res;
	endfunction

	// Stretches without any idling on either side, spaced through the run.
	function automatic bit quiet_phase();
		return (items_accepted / 150) % 4 == 3;
	endfunction

	// Idle length: mostly none or short, now and then long.
	function automatic int pick_gap(bit quiet);
		int roll;
		if (quiet)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	task automatic add_cmd(logic [OP_W-1:0] op, logic [DATA_W-1:0] value);
		queue_cmd_t cmd;
		cmd.op    = op;
		cmd.value = value;
		pending_cmds.push_back(cmd);
	endtask

	// Request driver: offers the next item at the falling edge once the last one is taken.
	always @(negedge clk) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
		end else if (req_took || !req.valid) begin
			if (send_gap > 0) begin
				send_gap--;
				req.valid <= 1'b0;
			end else if (pending_cmds.size() != 0) begin
				next_cmd = pending_cmds.pop_front();
				req.valid <= 1'b1;
				req.op    <= next_cmd.op;
				req.value <= next_cmd.value;
				send_gap = pick_gap(quiet_phase());
			end else begin
				req.valid <= 1'b0;
			end
		end
	end

	// Response receiver: random stalls, plus one long hold so the block backs up.
	always @(negedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			rsp.ready <= 1'b0;
		end else if (!backlog_done && items_accepted >= BACKLOG_AFTER) begin
			backlog_done = 1'b1;
			hold_left = BACKLOG_CYCLES - 1;
			rsp.ready <= 1'b0;
		end else if (rsp_took || $urandom_range(0, 15) == 0) begin
			stall = pick_gap(quiet_phase());
			if (stall > 0) begin
				hold_left = stall - 1;
				rsp.ready <= 1'b0;
			end else begin
				rsp.ready <= 1'b1;
			end
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// Monitor: predicts each accepted request and checks each accepted response.
	always @(posedge clk) begin
		if (!arst_n) begin
			req_took <= 1'b0;
			rsp_took <= 1'b0;
		end else begin
			req_took <= req.valid && req.ready;
			rsp_took <= rsp.valid && rsp.ready;
			if (req.valid && req.ready) begin
				taken_cmd.op    = req.op;
				taken_cmd.value = req.value;
				awaited_results.push_back(apply_queue_op(taken_cmd));
				op_count[req.op]++;
				items_accepted <= items_accepted + 1;
			end
			if (rsp.valid && rsp.ready) begin
				results_checked++;
				status_count[rsp.status]++;
				if (awaited_results.size() == 0) begin
					$error("unexpected result: status %0d, position %0d, occupancy %0d",
						rsp.status, rsp.position, rsp.occupancy);
					fail_count++;
				end else begin
					want = awaited_results.pop_front();
					if (want.status == ST_OK && want.position > deepest_remove)
						deepest_remove = want.position;
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
						fail_count++;
					end
					if (rsp.position !== want.position) begin
						$error("position: expected %0d, actual %0d",
							want.position, rsp.position);
						fail_count++;
					end
					if (rsp.occupancy !== want.occupancy) begin
						$error("occupancy: expected %0d, actual %0d",
							want.occupancy, rsp.occupancy);
						fail_count++;
					end
				end
			end
		end
	end

	// Watchdog: ends the run when no item moves on either channel for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin : stimulus
		int               n;
		int               k;
		int               roll;
		logic [OP_W-1:0]  op;
		logic [DATA_W-1:0] operand;

		// Directed: empty queue, extreme values, refusals, fill to capacity, full drain.
		add_cmd(OP_COUNT, 32'hDEAD_BEEF);
		add_cmd(OP_LOCATE, 32'h0000_0007);
		add_cmd(OP_REMOVE, 32'h0000_0007);
		add_cmd(OP_ENQ, 32'h8000_0000);
		add_cmd(OP_ENQ, 32'h7FFF_FFFF);
		add_cmd(OP_ENQ, 32'h7FFF_FFFF);
		add_cmd(OP_LOCATE, 32'h7FFF_FFFF);
		add_cmd(OP_LOCATE, 32'hFFFF_FFFF);
		add_cmd(OP_REMOVE, 32'h0000_0001);
		add_cmd(OP_REMOVE, 32'h8000_0000);
		add_cmd(OP_ENQ, 32'h0000_0000);
		add_cmd(OP_ENQ, 32'hFFFF_FFFF);
		add_cmd(OP_ENQ, 32'hAAAA_AAAA);
		add_cmd(OP_ENQ, 32'h5555_5555);
		for (k = 0; k < DEPTH - 5; k++)
			add_cmd(OP_ENQ, 32'h0000_1000 + k);
		// Full wins over duplicate when the value is already held.
		add_cmd(OP_ENQ, 32'hAAAA_AAAA);
		add_cmd(OP_COUNT, 32'h0000_0000);
		add_cmd(OP_LOCATE, 32'h0000_1000 + DEPTH - 6);
		add_cmd(OP_REMOVE, 32'h0000_1000 + DEPTH - 6);

		// Random: operands mostly from a small pool so hits, duplicates and
		// multi-entry removes are common; some fully random operands as noise.
		for (n = 0; n < RANDOM_CMDS; n++) begin
			if (n % 250 == 0) begin
				pool_used = $urandom_range(10, 28);
				for (k = 0; k < POOL_MAX; k++)
					value_pool[k] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 15) : $urandom;
			end
			if ($urandom_range(0, 99) < 10)
				operand = $urandom;
			else
				operand = value_pool[$urandom_range(0, pool_used - 1)];
			roll = $urandom_range(0, 99);
			if (roll < 45)
				op = OP_ENQ;
			else if (roll < 60)
				op = OP_REMOVE;
			else if (roll < 85)
				op = OP_LOCATE;
			else
				op = OP_COUNT;
			add_cmd(op, operand);
		end

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		while (pending_cmds.size() != 0 || req.valid)
			@(negedge clk);
		while (awaited_results.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("tb: %0d requests (enqueue %0d, remove %0d, locate %0d, count %0d), %0d results",
			items_accepted, op_count[OP_ENQ], op_count[OP_REMOVE], op_count[OP_LOCATE],
			op_count[OP_COUNT], results_checked);
		$display("tb: ok %0d, full %0d, duplicate %0d, empty %0d, not found %0d, deepest match %0d",
			status_count[ST_OK], status_count[ST_FULL], status_count[ST_DUP],
			status_count[ST_EMPTY], status_count[ST_NOTFOUND], deepest_remove);
		if (fail_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
